/* src/lbpc_pkg.sv */
// ----------------------------------------------------------------------------
// lbpc_pkg
// Shared types and constants of the LED blink pattern classifier.
// ----------------------------------------------------------------------------
package lbpc_pkg;

  localparam int CFG_W          = 14;
  localparam int CFG_IDX_W      = 3;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int PULSE_W        = 16;
  localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY    = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 14'd50;
  localparam logic [CFG_W-1:0] FAST_RST      = 14'd100;
  localparam logic [CFG_W-1:0] SLOW_RST      = 14'd1000;
  localparam logic [CFG_W-1:0] TOLERANCE_RST = 14'd50;
  localparam logic [CFG_W-1:0] STEADY_RST    = 14'd2000;

  typedef enum logic [2:0] {
    MODE_UNKNOWN = 3'd0,
    MODE_OFF     = 3'd1,
    MODE_ON      = 3'd2,
    MODE_SLOW    = 3'd3,
    MODE_FAST    = 3'd4
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] fast_period;
    logic [CFG_W-1:0] slow_period;
    logic [CFG_W-1:0] period_tolerance;
    logic [CFG_W-1:0] steady_threshold;
  } cfg_t;

endpackage

/* src/lbpc_step.sv */
// ----------------------------------------------------------------------------
// lbpc_step
// Next-state and result logic for one tick: debounce, pulse capture,
// period match and steady-level detection.
// ----------------------------------------------------------------------------
module lbpc_step #(
  parameter int COUNT_WIDTH = lbpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        led_level,
  input  logic                        prev_level,
  input  logic [COUNT_WIDTH-1:0]      since_edge,
  input  logic [COUNT_WIDTH-1:0]      last_pulse,
  input  lbpc_pkg::mode_t             mode,
  input  lbpc_pkg::cfg_t              cfg,
  output logic [COUNT_WIDTH-1:0]      since_edge_nxt,
  output logic [COUNT_WIDTH-1:0]      last_pulse_nxt,
  output lbpc_pkg::mode_t             mode_nxt,
  output logic                        mode_changed,
  output logic [lbpc_pkg::PULSE_W-1:0] pulse_ticks
);
  import lbpc_pkg::*;

  localparam int CMP_W = ((COUNT_WIDTH > PULSE_W) ? COUNT_WIDTH : PULSE_W) + 1;

  logic [COUNT_WIDTH-1:0] elapsed;
  logic                   edge_ok;
  logic [CMP_W-1:0]       pulse_x;
  logic [CMP_W-1:0]       fast_x;
  logic [CMP_W-1:0]       slow_x;
  logic [CMP_W-1:0]       diff_fast;
  logic [CMP_W-1:0]       diff_slow;
  logic [CMP_W-1:0]       t_x;
  logic [CMP_W-1:0]       thr_x;
  logic [CMP_W-1:0]       thr3_x;
  mode_t                  mode_cls;
  logic                   steady;

  // elapsed count saturates at all ones
  assign elapsed = (&since_edge) ? since_edge : since_edge + COUNT_WIDTH'(1);
  assign edge_ok = (led_level != prev_level) &&
                   (CMP_W'(elapsed) > CMP_W'(cfg.debounce_ticks));

  assign last_pulse_nxt = edge_ok ? elapsed : last_pulse;
  assign since_edge_nxt = edge_ok ? '0 : elapsed;

  assign pulse_x   = CMP_W'(last_pulse_nxt);
  assign fast_x    = CMP_W'(cfg.fast_period);
  assign slow_x    = CMP_W'(cfg.slow_period);
  assign diff_fast = (pulse_x >= fast_x) ? pulse_x - fast_x : fast_x - pulse_x;
  assign diff_slow = (pulse_x >= slow_x) ? pulse_x - slow_x : slow_x - pulse_x;

  // fresh pulse: fast wins when both periods match
  always_comb begin
    mode_cls = mode;
    if (edge_ok) begin
      if (diff_fast < CMP_W'(cfg.period_tolerance)) begin
        mode_cls = MODE_FAST;
      end else if (diff_slow < CMP_W'(cfg.period_tolerance)) begin
        mode_cls = MODE_SLOW;
      end
    end
  end

  assign t_x    = CMP_W'(since_edge_nxt);
  assign thr_x  = CMP_W'(cfg.steady_threshold);
  assign thr3_x = (thr_x << 1) + thr_x;
  assign steady = (t_x > thr_x) && ((t_x < thr3_x) || (mode_cls == MODE_UNKNOWN));

  assign mode_nxt     = steady ? (led_level ? MODE_OFF : MODE_ON) : mode_cls;
  assign mode_changed = (mode_nxt != mode);
  assign pulse_ticks  = (pulse_x > CMP_W'(PULSE_MAX)) ? PULSE_MAX
                                                      : PULSE_W'(last_pulse_nxt);

endmodule

/* src/led_blink_pattern_classifier.sv */
// ----------------------------------------------------------------------------
// led_blink_pattern_classifier
// Classifies a sampled LED pin (one word per tick) as off, on, slow or fast
// blinking.
//
//   channel | dir | handshake             | payload
//   in_     | in  | in_tvalid / in_tready | in_tdata:  led_level
//   out_    | out | out_tvalid/out_tready | out_tdata: led_mode, mode_changed,
//           |     |                       |            pulse_ticks
//   cfg_    | in  | cfg_we                | cfg_index, cfg_wdata
//
// One word per cycle while out_tready holds; a word passes the input register,
// then the tick logic, then the result register.
// The classifier state updates as a word moves into the result register.
// A stalled result blocks the input register; in_tready drops only when both
// hold a word. Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module led_blink_pattern_classifier #(
  parameter int COUNT_WIDTH = lbpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [0] led_level
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // [2:0] led_mode, [3] mode_changed,
                                                    // [19:4] pulse_ticks
  input  logic                          cfg_we,
  input  logic [lbpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbpc_pkg::CFG_W-1:0]    cfg_wdata
);
  import lbpc_pkg::*;

  cfg_t                   cfg_r;
  logic                   s1_v_r;
  logic                   s1_level_r;
  logic                   out_v_r;
  mode_t                  out_mode_r;
  logic                   out_changed_r;
  logic [PULSE_W-1:0]     out_pulse_r;

  logic                   prev_level_r;
  logic [COUNT_WIDTH-1:0] since_edge_r;
  logic [COUNT_WIDTH-1:0] last_pulse_r;
  mode_t                  mode_r;

  logic [COUNT_WIDTH-1:0] since_edge_nxt;
  logic [COUNT_WIDTH-1:0] last_pulse_nxt;
  mode_t                  mode_nxt;
  logic                   changed_nxt;
  logic [PULSE_W-1:0]     pulse_nxt;

  logic                   adv;
  logic                   in_fire;
  logic                   step;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign step      = s1_v_r && adv;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, out_pulse_r, out_changed_r, out_mode_r};

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.fast_period      <= FAST_RST;
      cfg_r.slow_period      <= SLOW_RST;
      cfg_r.period_tolerance <= TOLERANCE_RST;
      cfg_r.steady_threshold <= STEADY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  cfg_r.debounce_ticks   <= cfg_wdata;
        REG_FAST:      cfg_r.fast_period      <= cfg_wdata;
        REG_SLOW:      cfg_r.slow_period      <= cfg_wdata;
        REG_TOLERANCE: cfg_r.period_tolerance <= cfg_wdata;
        REG_STEADY:    cfg_r.steady_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lbpc_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .led_level      (s1_level_r),
    .prev_level     (prev_level_r),
    .since_edge     (since_edge_r),
    .last_pulse     (last_pulse_r),
    .mode           (mode_r),
    .cfg            (cfg_r),
    .since_edge_nxt (since_edge_nxt),
    .last_pulse_nxt (last_pulse_nxt),
    .mode_nxt       (mode_nxt),
    .mode_changed   (changed_nxt),
    .pulse_ticks    (pulse_nxt)
  );

  // control and classifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      prev_level_r <= 1'b1;
      since_edge_r <= '0;
      last_pulse_r <= '0;
      mode_r       <= MODE_UNKNOWN;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
      if (step) begin
        prev_level_r <= s1_level_r;
        since_edge_r <= since_edge_nxt;
        last_pulse_r <= last_pulse_nxt;
        mode_r       <= mode_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level_r <= in_tdata[0];
    end
    if (step) begin
      out_mode_r    <= mode_nxt;
      out_changed_r <= changed_nxt;
      out_pulse_r   <= pulse_nxt;
    end
  end

`ifndef SYNTHESIS
  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("in_tready low with empty result register");

  // classifier state moves only with a word
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(mode_r))
    else $error("mode changed without a word");

  // change flag matches the state update it reports
  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (out_changed_r == (mode_r != $past(mode_r))))
    else $error("mode_changed disagrees with mode update");

  // an accepted edge always records a nonzero pulse
  a_pulse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (since_edge_nxt == '0)) |=> (out_pulse_r != '0))
    else $error("accepted edge recorded zero pulse");
`endif

endmodule
